[hw/rtl/cv2d_pkg.sv]
package cv2d_pkg;

   localparam int SampleW   = 16;
   localparam int CoefIdxW  = 6;
   localparam int ConvW     = 40;
   localparam int PosW      = 9;
   localparam int KStore    = 8;
   localparam int CsrAddrW  = 5;
   localparam int CsrDataW  = 32;
   localparam int KernW     = 4;
   localparam int NumCoef   = 64;

   typedef enum logic {
      REQ_COEF   = 1'b0,
      REQ_SAMPLE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      CROP_FULL  = 2'd0,
      CROP_SAME  = 2'd1,
      CROP_VALID = 2'd2
   } crop_type;

   typedef enum logic [2:0] {
      REG_IMAGE_ROWS  = 3'd0,
      REG_IMAGE_COLS  = 3'd1,
      REG_KERNEL_ROWS = 3'd2,
      REG_KERNEL_COLS = 3'd3,
      REG_CROP_MODE   = 3'd4,
      REG_FLIP_KERNEL = 3'd5
   } reg_index_type;

endpackage

[hw/rtl/cv2d_ifs.sv]
interface cv2d_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 req_type;
   logic [cv2d_pkg::CoefIdxW-1:0]        coef_index;
   logic signed [cv2d_pkg::SampleW-1:0]  coef_value;
   logic signed [cv2d_pkg::SampleW-1:0]  sample;

   modport source (output valid, req_type, coef_index, coef_value, sample, input ready);
   modport sink (input valid, req_type, coef_index, coef_value, sample, output ready);
endinterface

interface cv2d_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [cv2d_pkg::ConvW-1:0]   conv_value;
   logic [cv2d_pkg::PosW-1:0]           out_row;
   logic [cv2d_pkg::PosW-1:0]           out_col;
   logic                                last;

   modport source (output valid, conv_value, out_row, out_col, last, input ready);
   modport sink (input valid, conv_value, out_row, out_col, last, output ready);
endinterface

[hw/rtl/conv2d_full_same_valid.sv]
// A result beat passes through the stage 1, window, product, row sum and output registers.
// Throughput: one beat per cycle outside the coefficient remap, set by the single-port line bank
// memories and the fully parallel window of multipliers; a stalled output holds the whole pipeline.
// Reset is synchronous and active high; it loads the register defaults and starts a coefficient
// remap that refuses input across min(MAX_KERNEL, 8) squared tap positions and writes its last
// tap in the cycle after; every register write starts the same remap and restarts the frame.
module conv2d_full_same_valid #(
   parameter int MAX_IMG_SIZE = 256,
   parameter int MAX_KERNEL   = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   cv2d_req_if.sink                        req,
   cv2d_rsp_if.source                      rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cv2d_pkg::CsrAddrW-1:0]   csr_paddr,
   input  logic [cv2d_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic [cv2d_pkg::CsrDataW-1:0]   csr_prdata,
   output logic                            csr_pready
);

   localparam int KL  = (MAX_KERNEL < cv2d_pkg::KStore) ? MAX_KERNEL : cv2d_pkg::KStore;
   localparam int JW  = $clog2(KL);
   localparam int IW  = $clog2(MAX_IMG_SIZE + 1);
   localparam int GW  = $clog2(MAX_IMG_SIZE + KL);
   localparam int CW  = GW + 2;
   localparam int AW  = $clog2(MAX_IMG_SIZE);
   localparam int SW  = cv2d_pkg::SampleW;
   localparam int PW  = 2 * SW;
   localparam int RSW = PW + JW;
   localparam int TW  = RSW + JW;
   localparam int KW  = cv2d_pkg::KernW;
   localparam int PSW = cv2d_pkg::PosW;

   // Configuration registers.
   logic [IW-1:0] rows_ff, cols_ff, rows_in, cols_in;
   logic [KW-1:0] krow_ff, kcol_ff, krow_in, kcol_in;
   logic [1:0]    crop_ff;
   logic          flip_ff;
   logic          cfg_wr, cfg_restart;
   cv2d_pkg::reg_index_type reg_idx;

   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = cv2d_pkg::reg_index_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;

   always_comb begin
      if (csr_pwdata == '0) begin
         rows_in = IW'(1);
         krow_in = KW'(1);
      end else begin
         rows_in = (csr_pwdata > 32'(MAX_IMG_SIZE)) ? IW'(MAX_IMG_SIZE) : IW'(csr_pwdata);
         krow_in = (csr_pwdata > 32'(KL)) ? KW'(KL) : KW'(csr_pwdata);
      end
      cols_in = rows_in;
      kcol_in = krow_in;
      case (reg_idx)
         cv2d_pkg::REG_IMAGE_ROWS,
         cv2d_pkg::REG_IMAGE_COLS,
         cv2d_pkg::REG_KERNEL_ROWS,
         cv2d_pkg::REG_KERNEL_COLS,
         cv2d_pkg::REG_CROP_MODE,
         cv2d_pkg::REG_FLIP_KERNEL: cfg_restart = cfg_wr;
         default:                   cfg_restart = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= IW'(1);
         cols_ff <= IW'(1);
         krow_ff <= KW'(1);
         kcol_ff <= KW'(1);
         crop_ff <= cv2d_pkg::CROP_FULL;
         flip_ff <= 1'b1;
      end else if (cfg_wr) begin
         case (reg_idx)
            cv2d_pkg::REG_IMAGE_ROWS:  rows_ff <= rows_in;
            cv2d_pkg::REG_IMAGE_COLS:  cols_ff <= cols_in;
            cv2d_pkg::REG_KERNEL_ROWS: krow_ff <= krow_in;
            cv2d_pkg::REG_KERNEL_COLS: kcol_ff <= kcol_in;
            cv2d_pkg::REG_CROP_MODE:   crop_ff <= csr_pwdata[1:0];
            cv2d_pkg::REG_FLIP_KERNEL: flip_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         cv2d_pkg::REG_IMAGE_ROWS:  csr_prdata = 32'(rows_ff);
         cv2d_pkg::REG_IMAGE_COLS:  csr_prdata = 32'(cols_ff);
         cv2d_pkg::REG_KERNEL_ROWS: csr_prdata = 32'(krow_ff);
         cv2d_pkg::REG_KERNEL_COLS: csr_prdata = 32'(kcol_ff);
         cv2d_pkg::REG_CROP_MODE:   csr_prdata = 32'(crop_ff);
         cv2d_pkg::REG_FLIP_KERNEL: csr_prdata = 32'(flip_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // Grid geometry and crop.
   logic [GW-1:0] gh, gw;
   logic [KW-1:0] krm1, kcm1;
   logic          both_even;
   logic [2:0]    hr, hc;
   logic [3:0]    sr, sc;
   logic [CW-1:0] ghx, gwx, grx, gcx, srx, scx;

   assign gh   = GW'(rows_ff) + GW'(krow_ff) - GW'(1);
   assign gw   = GW'(cols_ff) + GW'(kcol_ff) - GW'(1);
   assign krm1 = krow_ff - KW'(1);
   assign kcm1 = kcol_ff - KW'(1);
   assign both_even = !krow_ff[0] && !kcol_ff[0];
   assign hr = both_even ? krow_ff[3:1] : krm1[3:1];
   assign hc = both_even ? kcol_ff[3:1] : kcm1[3:1];

   always_comb begin
      case (cv2d_pkg::crop_type'(crop_ff))
         cv2d_pkg::CROP_SAME: begin
            sr = {1'b0, hr};
            sc = {1'b0, hc};
         end
         cv2d_pkg::CROP_VALID: begin
            sr = both_even ? {hr, 1'b0} - 4'd1 : {hr, 1'b0};
            sc = both_even ? {hc, 1'b0} - 4'd1 : {hc, 1'b0};
         end
         default: begin
            sr = 4'd0;
            sc = 4'd0;
         end
      endcase
   end

   // Handshake and grid position.
   logic en, acc, is_smp, is_coef, inimg, colok0;
   logic rsp_valid_ff, sw_busy_ff;
   logic [GW-1:0] gr_ff, gc_ff, gr_in, gc_in;
   logic [JW-1:0] bank_ff, bank_in;
   logic [KL-1:0] rowok0;
   logic [JW-1:0] sel0 [KL];
   logic          emit0, last0;
   logic [PSW-1:0] orow0, ocol0;

   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en && !sw_busy_ff;
   assign acc       = req.valid && req.ready;
   assign is_smp    = acc && (cv2d_pkg::req_kind_type'(req.req_type) == cv2d_pkg::REQ_SAMPLE);
   assign is_coef   = acc && (cv2d_pkg::req_kind_type'(req.req_type) == cv2d_pkg::REQ_COEF);

   assign grx = CW'(gr_ff);
   assign gcx = CW'(gc_ff);
   assign ghx = CW'(gh);
   assign gwx = CW'(gw);
   assign srx = CW'(sr);
   assign scx = CW'(sc);

   assign colok0 = gc_ff < GW'(cols_ff);
   assign inimg  = colok0 && (gr_ff < GW'(rows_ff));
   assign emit0  = (ghx > (srx << 1)) && (gwx > (scx << 1)) && (grx >= srx) &&
                   (grx < ghx - srx) && (gcx >= scx) && (gcx < gwx - scx);
   assign orow0  = PSW'(grx - srx);
   assign ocol0  = PSW'(gcx - scx);
   assign last0  = (grx == ghx - srx - CW'(1)) && (gcx == gwx - scx - CW'(1));

   always_comb begin
      for (int j = 0; j < KL; j++) begin
         rowok0[j] = colok0 && (grx >= CW'(j)) && (grx - CW'(j) < CW'(rows_ff));
         sel0[j]   = (bank_ff >= JW'(j)) ? bank_ff - JW'(j) : bank_ff + JW'(KL - j);
      end
      gc_in   = gc_ff + GW'(1);
      gr_in   = gr_ff;
      bank_in = bank_ff;
      if (gc_in >= gw) begin
         gc_in   = '0;
         gr_in   = gr_ff + GW'(1);
         bank_in = (bank_ff == JW'(KL - 1)) ? '0 : bank_ff + JW'(1);
         if (gr_in >= gh) begin
            gr_in   = '0;
            bank_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_restart) begin
         gr_ff   <= '0;
         gc_ff   <= '0;
         bank_ff <= '0;
      end else if (is_smp) begin
         gr_ff   <= gr_in;
         gc_ff   <= gc_in;
         bank_ff <= bank_in;
      end
   end

   // Line banks: one image row each, written by the current row, read at the current column.
   logic [AW-1:0]        addr0;
   logic signed [SW-1:0] rd_ff [KL];

   assign addr0 = AW'(gc_ff);

   for (genvar b = 0; b < KL; b++) begin : g_bank
      logic signed [SW-1:0] mem [MAX_IMG_SIZE];
      always_ff @(posedge clock) begin
         if (is_smp && inimg && bank_ff == JW'(b)) begin
            mem[addr0] <= req.sample;
         end
         if (en) begin
            rd_ff[b] <= mem[addr0];
         end
      end
   end

   // Coefficient store and remap into the tap registers.
   logic signed [SW-1:0] cmem [cv2d_pkg::NumCoef];
   logic signed [SW-1:0] cmem_rd_ff;
   logic [JW-1:0] sw_j_ff, sw_m_ff, sw_tj_ff, sw_tm_ff;
   logic          sw_we_ff, sw_zero_ff, sw_inr;
   logic [KW-1:0] sw_r, sw_c;
   logic [cv2d_pkg::CoefIdxW-1:0] sw_addr;

   assign sw_r    = flip_ff ? KW'(sw_j_ff) : krm1 - KW'(sw_j_ff);
   assign sw_c    = flip_ff ? KW'(sw_m_ff) : kcm1 - KW'(sw_m_ff);
   assign sw_addr = {sw_r[2:0], sw_c[2:0]};
   assign sw_inr  = (KW'(sw_j_ff) < krow_ff) && (KW'(sw_m_ff) < kcol_ff);

   always_ff @(posedge clock) begin
      if (is_coef) begin
         cmem[req.coef_index] <= req.coef_value;
      end
      if (sw_busy_ff) begin
         cmem_rd_ff <= cmem[sw_addr];
      end
      sw_tj_ff   <= sw_j_ff;
      sw_tm_ff   <= sw_m_ff;
      sw_zero_ff <= !sw_inr;
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_restart) begin
         sw_busy_ff <= 1'b1;
         sw_j_ff    <= '0;
         sw_m_ff    <= '0;
         sw_we_ff   <= 1'b0;
      end else begin
         sw_we_ff <= sw_busy_ff;
         if (sw_busy_ff) begin
            if (sw_m_ff == JW'(KL - 1)) begin
               sw_m_ff <= '0;
               if (sw_j_ff == JW'(KL - 1)) begin
                  sw_busy_ff <= 1'b0;
               end else begin
                  sw_j_ff <= sw_j_ff + JW'(1);
               end
            end else begin
               sw_m_ff <= sw_m_ff + JW'(1);
            end
         end
      end
   end

   // Stage 1: window column build and direct coefficient update.
   logic v1_ff, c1_ff;
   logic signed [SW-1:0] smp1_ff, tv1_ff;
   logic [KL-1:0] rowok1_ff;
   logic [JW-1:0] sel1_ff [KL];
   logic [JW-1:0] tj1_ff, tm1_ff, tj0, tm0;
   logic          twe1_ff, twe0;
   logic [GW-1:0] gc1_ff, gc2_ff;
   logic          emit1_ff, last1_ff, v2_ff, emit2_ff, last2_ff;
   logic [PSW-1:0] orow1_ff, ocol1_ff, orow2_ff, ocol2_ff;
   logic [KW-1:0] cr0, cc0;

   assign cr0  = {1'b0, req.coef_index[5:3]};
   assign cc0  = {1'b0, req.coef_index[2:0]};
   assign twe0 = (cr0 < krow_ff) && (cc0 < kcol_ff);
   assign tj0  = flip_ff ? JW'(cr0) : JW'(krm1 - cr0);
   assign tm0  = flip_ff ? JW'(cc0) : JW'(kcm1 - cc0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         c1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= is_smp;
         c1_ff <= is_coef;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         smp1_ff   <= inimg ? req.sample : '0;
         rowok1_ff <= rowok0;
         sel1_ff   <= sel0;
         gc1_ff    <= gc_ff;
         emit1_ff  <= emit0;
         last1_ff  <= last0;
         orow1_ff  <= orow0;
         ocol1_ff  <= ocol0;
         tj1_ff    <= tj0;
         tm1_ff    <= tm0;
         tv1_ff    <= req.coef_value;
         twe1_ff   <= twe0;
         gc2_ff    <= gc1_ff;
         emit2_ff  <= emit1_ff;
         last2_ff  <= last1_ff;
         orow2_ff  <= orow1_ff;
         ocol2_ff  <= ocol1_ff;
      end
   end

   logic signed [SW-1:0] colv [KL];
   logic signed [SW-1:0] win_ff [KL][KL];
   logic signed [SW-1:0] tap_ff [KL][KL];

   always_comb begin
      for (int j = 0; j < KL; j++) begin
         if (!rowok1_ff[j]) begin
            colv[j] = '0;
         end else if (j == 0) begin
            colv[j] = smp1_ff;
         end else begin
            colv[j] = rd_ff[sel1_ff[j]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < KL; j++) begin
            for (int m = 0; m < KL; m++) begin
               win_ff[j][m] <= '0;
            end
         end
      end else if (en && v1_ff) begin
         for (int j = 0; j < KL; j++) begin
            win_ff[j][0] <= colv[j];
            for (int m = 1; m < KL; m++) begin
               win_ff[j][m] <= win_ff[j][m-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en && c1_ff && twe1_ff) begin
         tap_ff[tj1_ff][tm1_ff] <= tv1_ff;
      end else if (sw_we_ff) begin
         tap_ff[sw_tj_ff][sw_tm_ff] <= sw_zero_ff ? '0 : cmem_rd_ff;
      end
   end

   // Stage 3: products; stage 4: row sums; then the output register.
   logic signed [PW-1:0]  p_ff [KL][KL];
   logic signed [RSW-1:0] rs_ff [KL];
   logic signed [RSW-1:0] rs_in [KL];
   logic signed [TW-1:0]  total;
   logic v3_ff, v4_ff, emit3_ff, emit4_ff, last3_ff, last4_ff;
   logic [PSW-1:0] orow3_ff, ocol3_ff, orow4_ff, ocol4_ff;
   logic signed [cv2d_pkg::ConvW-1:0] conv_ff;
   logic [PSW-1:0] orow_ff, ocol_ff;
   logic           last_ff;

   always_ff @(posedge clock) begin
      if (en && v2_ff) begin
         for (int j = 0; j < KL; j++) begin
            for (int m = 0; m < KL; m++) begin
               if (GW'(m) <= gc2_ff) begin
                  p_ff[j][m] <= win_ff[j][m] * tap_ff[j][m];
               end else begin
                  p_ff[j][m] <= '0;
               end
            end
         end
      end
   end

   always_comb begin
      total = '0;
      for (int j = 0; j < KL; j++) begin
         rs_in[j] = '0;
         for (int m = 0; m < KL; m++) begin
            rs_in[j] = rs_in[j] + RSW'(p_ff[j][m]);
         end
         total = total + TW'(rs_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff && emit4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         emit3_ff <= emit2_ff;
         last3_ff <= last2_ff;
         orow3_ff <= orow2_ff;
         ocol3_ff <= ocol2_ff;
         emit4_ff <= emit3_ff;
         last4_ff <= last3_ff;
         orow4_ff <= orow3_ff;
         ocol4_ff <= ocol3_ff;
         if (v3_ff) begin
            rs_ff <= rs_in;
         end
         conv_ff <= cv2d_pkg::ConvW'(total);
         orow_ff <= orow4_ff;
         ocol_ff <= ocol4_ff;
         last_ff <= last4_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.conv_value = conv_ff;
   assign rsp.out_row    = orow_ff;
   assign rsp.out_col    = ocol_ff;
   assign rsp.last       = last_ff;

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !req.ready)
      else $error("Input taken while the output beat is stalled.");

   a_remap_blocks_input: assert property (@(posedge clock) disable iff (reset)
      sw_busy_ff |-> !req.ready)
      else $error("Input taken during the coefficient remap.");

   a_restart_frame: assert property (@(posedge clock) disable iff (reset)
      cfg_restart |=> (gr_ff == '0 && gc_ff == '0 && sw_busy_ff))
      else $error("Register write did not restart the frame.");

   a_grid_in_range: assert property (@(posedge clock) disable iff (reset)
      (gc_ff < gw) && (gr_ff < gh))
      else $error("Grid position outside the padded grid.");

endmodule

[verif/cv2d_checker.sv]
module cv2d_checker
   import cv2d_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   cv2d_req_if                 req,
   cv2d_rsp_if                 rsp,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic                csr_pready,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output int                  fail_count,
   output int                  pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [ConvW-1:0] value;
      logic [PosW-1:0]         row;
      logic [PosW-1:0]         col;
      logic                    last;
   } conv_beat_type;

   conv_beat_type conv_expected[$];

   int img_rows, img_cols, k_rows, k_cols, grow, gcol;
   logic [1:0] crop;
   logic flip;
   logic signed [SampleW-1:0] coefs[NumCoef];
   logic signed [SampleW-1:0] lines[8][256];

   function automatic int clamp_size(logic [CsrDataW-1:0] v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   function automatic int crop_edge(int k, bit even);
      int h;
      h = even ? k / 2 : (k - 1) / 2;
      if (crop == CROP_SAME) return h;
      if (crop == CROP_VALID) return even ? 2 * h - 1 : 2 * h;
      return 0;
   endfunction

   function automatic void predict_sample(logic signed [SampleW-1:0] s);
      int gh, gw, ir, ic, ri, ci, sr, sc;
      longint acc;
      bit even;
      conv_beat_type b;
      gh = img_rows + k_rows - 1;
      gw = img_cols + k_cols - 1;
      acc = 0;
      if (grow < img_rows && gcol < img_cols) lines[grow % 8][gcol] = s;
      for (int r = 0; r < k_rows; r++) begin
         ir = grow + r - (k_rows - 1);
         if (ir < 0 || ir >= img_rows) continue;
         for (int c = 0; c < k_cols; c++) begin
            ic = gcol + c - (k_cols - 1);
            if (ic < 0 || ic >= img_cols) continue;
            ri = flip ? k_rows - 1 - r : r;
            ci = flip ? k_cols - 1 - c : c;
            acc += longint'(coefs[ri * KStore + ci]) * longint'(lines[ir % 8][ic]);
         end
      end
      even = (k_rows % 2 == 0) && (k_cols % 2 == 0);
      sr = crop_edge(k_rows, even);
      sc = crop_edge(k_cols, even);
      if (gh > 2 * sr && gw > 2 * sc && grow >= sr && grow < gh - sr &&
          gcol >= sc && gcol < gw - sc) begin
         b.value = acc[ConvW-1:0];
         b.row = PosW'(grow - sr);
         b.col = PosW'(gcol - sc);
         b.last = (grow == gh - sr - 1) && (gcol == gw - sc - 1);
         conv_expected.push_back(b);
      end
      gcol++;
      if (gcol >= gw) begin
         gcol = 0;
         grow++;
         if (grow >= gh) grow = 0;
      end
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("conv mismatch: %s got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      conv_beat_type w;
      if (reset) begin
         img_rows = 1; img_cols = 1; k_rows = 1; k_cols = 1;
         crop = CROP_FULL; flip = 1'b1; grow = 0; gcol = 0;
         conv_expected.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[4:2]))
               REG_IMAGE_ROWS:  img_rows = clamp_size(csr_pwdata, 256);
               REG_IMAGE_COLS:  img_cols = clamp_size(csr_pwdata, 256);
               REG_KERNEL_ROWS: k_rows = clamp_size(csr_pwdata, 8);
               REG_KERNEL_COLS: k_cols = clamp_size(csr_pwdata, 8);
               REG_CROP_MODE:   crop = csr_pwdata[1:0];
               REG_FLIP_KERNEL: flip = csr_pwdata[0];
               default: ;
            endcase
            if (csr_paddr[4:2] <= REG_FLIP_KERNEL) begin
               grow = 0;
               gcol = 0;
            end
         end
         if (req.valid && req.ready) begin
            if (req.req_type == REQ_COEF) coefs[req.coef_index] = req.coef_value;
            else predict_sample(req.sample);
         end
         if (rsp.valid && rsp.ready) begin
            if (conv_expected.size() == 0) begin
               report("unexpected result beat", rsp.conv_value, 0);
            end else begin
               w = conv_expected.pop_front();
               if (rsp.conv_value !== w.value) report("conv_value", rsp.conv_value, w.value);
               if (rsp.out_row !== w.row) report("out_row", rsp.out_row, w.row);
               if (rsp.out_col !== w.col) report("out_col", rsp.out_col, w.col);
               if (rsp.last !== w.last) report("last", rsp.last, w.last);
            end
         end
      end
      pending = conv_expected.size();
   end
endmodule

[verif/tb.sv]
module tb;
   import cv2d_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 600000;

   logic clock, reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [CsrDataW-1:0] csr_pwdata, csr_prdata;
   int fail_count, pending, sent, cycles;
   bit gaps_on, hold_rsp;

   cv2d_req_if req_ch();
   cv2d_rsp_if rsp_ch();

   conv2d_full_same_valid dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   cv2d_checker chk (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // The receiver stalls in short bursts, or once for a long stretch on request.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic logic signed [SampleW-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         default: return SampleW'($urandom);
      endcase
   endfunction

   function automatic int clamp_size(int v, int hi);
      return v < 1 ? 1 : (v > hi ? hi : v);
   endfunction

   task automatic offer(req_kind_type kind, logic [CoefIdxW-1:0] idx,
                        logic signed [SampleW-1:0] cv, logic signed [SampleW-1:0] s);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.coef_index <= idx;
      req_ch.coef_value <= cv;
      req_ch.sample <= s;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sent++;
   endtask

   task automatic csr_write(reg_index_type r, logic [CsrDataW-1:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {r, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic run_phase(int rows, int cols, int kr, int kc, int mode, int flip,
                            int frames, bit hold);
      int beats;
      wait_idle();
      csr_write(REG_IMAGE_ROWS, rows);
      csr_write(REG_IMAGE_COLS, cols);
      csr_write(REG_KERNEL_ROWS, kr);
      csr_write(REG_KERNEL_COLS, kc);
      csr_write(REG_CROP_MODE, mode);
      csr_write(REG_FLIP_KERNEL, flip);
      beats = (clamp_size(rows, 256) + clamp_size(kr, 8) - 1) *
              (clamp_size(cols, 256) + clamp_size(kc, 8) - 1) * frames;
      repeat ($urandom_range(0, 6))
         offer(REQ_COEF, CoefIdxW'($urandom), pick_value(), SampleW'($urandom));
      if (hold) hold_rsp = 1'b1;
      repeat (beats) begin
         if ($urandom_range(0, 15) == 0)
            offer(REQ_COEF, CoefIdxW'($urandom), pick_value(), SampleW'($urandom));
         offer(REQ_SAMPLE, CoefIdxW'($urandom), SampleW'($urandom), pick_value());
      end
      req_ch.valid <= 1'b0;
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.req_type = REQ_COEF;
      req_ch.coef_index = '0;
      req_ch.coef_value = '0;
      req_ch.sample = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      gaps_on = 1'b1;
      hold_rsp = 1'b0;
      sent = 0;
      cycles = 0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NumCoef; i++)
         offer(REQ_COEF, CoefIdxW'(i), pick_value(), SampleW'($urandom));
      offer(REQ_SAMPLE, '0, '0, 16'sh7fff);
      req_ch.valid <= 1'b0;

      run_phase(0, 300, 0, 15, 3, 0, 1, 1'b1);
      run_phase(511, 1, 8, 1, CROP_FULL, 1, 1, 1'b0);
      run_phase(2, 2, 5, 5, CROP_VALID, 1, 1, 1'b0);
      run_phase(3, 5, 4, 2, CROP_SAME, 0, 2, 1'b0);
      run_phase(4, 4, 3, 3, CROP_VALID, 1, 1, 1'b0);
      run_phase(5, 6, 4, 4, CROP_VALID, 0, 1, 1'b0);

      while (sent < 1400) begin
         gaps_on = (sent < 1150) && ($urandom_range(0, 3) != 0);
         run_phase($urandom_range(1, 6), $urandom_range(1, 10), $urandom_range(1, 8),
                   $urandom_range(1, 8), $urandom_range(0, 3), $urandom_range(0, 1),
                   $urandom_range(1, 2), 1'b0);
      end

      wait_idle();
      if (fail_count == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end
endmodule

[files.f]
hw/rtl/cv2d_pkg.sv
hw/rtl/cv2d_ifs.sv
hw/rtl/conv2d_full_same_valid.sv
verif/cv2d_checker.sv
verif/tb.sv
